// ===== rtl/core/scr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scr_pkg
// Shared types and codes for the single-slot command retry buffer.
// ----------------------------------------------------------------------------
package scr_pkg;

  // Fixed field widths
  localparam int DATA_W = 8;
  localparam int CNT_W  = 7;
  localparam int TIME_W = 32;
  localparam int ID_W   = 32;

  // Register indexes (word address bit 2)
  localparam logic REG_RETRY_DELAY = 1'b0;

  // Input beat kinds
  typedef enum logic [1:0] {
    KIND_STORE   = 2'd0,
    KIND_PEEK    = 2'd1,
    KIND_FINISH  = 2'd2,
    KIND_DISCARD = 2'd3
  } kind_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_BAD           = 3'd1,
    ST_FULL          = 3'd2,
    ST_EMPTY         = 3'd3,
    ST_NOT_READY     = 3'd4,
    ST_CONFLICT      = 3'd5,
    ST_NOT_DISCARDED = 3'd6
  } status_t;

  // Sequencer states, one-hot
  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_REPLAY = 2'b10
  } state_t;

  // One result beat
  typedef struct packed {
    status_t             status;
    logic                pending;
    logic [DATA_W-1:0]   data_b;
    logic                last;
    logic [CNT_W-1:0]    length;
    logic [ID_W-1:0]     cmd_id;
    logic [DATA_W-1:0]   msg_type;
    logic [DATA_W-1:0]   src_node;
  } beat_t;

endpackage

// ===== rtl/core/single_slot_command_retry.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_slot_command_retry
// One-slot stop-and-wait retransmit buffer: collects a command frame, holds
// it with a retry deadline and replays it from a frame RAM on request.
// ----------------------------------------------------------------------------
//  channel | dir | beat content
//  in_*    | in  | tuser: kind; tlast: data_last; tdata: time, ids, header,
//          |     |   frame byte, link_ready, succeeded
//  out_*   | out | tuser: status; tlast: last beat of a reply; tdata: pending,
//          |     |   frame byte, length, cmd_id, msg_type, src_node
//  cfg_*   | in  | APB register port, retry_delay_ms at byte address 0
//
//  Every command is one input beat; a non-final store byte makes no beat, all
//  other commands but a successful peek put one beat in the output register.
//  A successful peek of an L-byte frame gives L beats, one per cycle unless the
//  output is held, after a first frame RAM read; the input is held off meanwhile.
//  Input is taken whenever the sequencer is idle and the output register is
//  empty or being emptied in the same cycle.
//  Synchronous active-low reset; the frame RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module single_slot_command_retry
  import scr_pkg::*;
#(
  parameter int FRAME_BYTES = 64,
  parameter int NODE_LIMIT  = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] now_ms, [63:32] cmd_id, [95:64] sess_id, [103:96] msg_type,
  // [111:104] src_node, [119:112] data_byte, [120] link_ready,
  // [121] succeeded, [127:122] zero
  input  logic [127:0] in_tdata,
  input  logic [1:0]   in_tuser,   // [1:0] kind
  input  logic         in_tlast,   // data_last
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // [0] slot_pending, [8:1] out_byte, [15:9] out_length, [47:16] out_cmd_id,
  // [55:48] out_msg_type, [63:56] out_src_node
  output logic [63:0]  out_tdata,
  output logic [2:0]   out_tuser,  // [2:0] status
  output logic         out_tlast,  // out_last
  // register port
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam logic [CNT_W-1:0]  FB_CNT   = CNT_W'(FRAME_BYTES);
  localparam logic [DATA_W-1:0] NODE_MAX = DATA_W'(NODE_LIMIT);
  localparam logic [15:0]       DELAY_RST = 16'd100;

  // input fields
  kind_t              in_kind;
  logic [TIME_W-1:0]  in_now;
  logic [ID_W-1:0]    in_cmd;
  logic [ID_W-1:0]    in_sess;
  logic [DATA_W-1:0]  in_mtype;
  logic [DATA_W-1:0]  in_src;
  logic [DATA_W-1:0]  in_dbyte;
  logic               in_link;
  logic               in_succ;

  assign in_kind  = kind_t'(in_tuser);
  assign in_now   = in_tdata[31:0];
  assign in_cmd   = in_tdata[63:32];
  assign in_sess  = in_tdata[95:64];
  assign in_mtype = in_tdata[103:96];
  assign in_src   = in_tdata[111:104];
  assign in_dbyte = in_tdata[119:112];
  assign in_link  = in_tdata[120];
  assign in_succ  = in_tdata[121];

  // register port
  logic [15:0] delay_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_RETRY_DELAY) ? {16'd0, delay_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_RST;
    end else if (cfg_wr && (cfg_paddr[2] == REG_RETRY_DELAY)) begin
      delay_r <= cfg_pwdata[15:0];
    end
  end

  // slot, store-run and sequencer state
  state_t             state_r,    state_nxt;
  logic               pend_r,     pend_nxt;
  logic [CNT_W-1:0]   len_r,      len_nxt;
  logic [ID_W-1:0]    hcmd_r,     hcmd_nxt;
  logic [ID_W-1:0]    hsess_r,    hsess_nxt;
  logic [TIME_W-1:0]  dl_r,       dl_nxt;
  logic [DATA_W-1:0]  hmtype_r,   hmtype_nxt;
  logic [DATA_W-1:0]  hsrc_r,     hsrc_nxt;
  logic [CNT_W-1:0]   bc_r,       bc_nxt;
  logic               ovf_r,      ovf_nxt;
  logic               blk_r,      blk_nxt;
  logic [CNT_W-1:0]   rd_addr_r,  rd_addr_nxt;
  logic [CNT_W-1:0]   ld_cnt_r,   ld_cnt_nxt;
  logic               rd_vld_r,   rd_vld_nxt;
  logic               out_valid_r, out_valid_nxt;
  beat_t              out_r,      out_nxt;

  // frame RAM
  logic               ram_we;
  logic               ram_re;
  logic [DATA_W-1:0]  ram_rdata;

  scr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (FRAME_BYTES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (bc_r[AW-1:0]),
    .wdata (in_dbyte),
    .re    (ram_re),
    .raddr (rd_addr_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // shared datapath terms
  logic               out_free;
  logic               in_fire;
  logic               room;
  logic               src_ok;
  logic [TIME_W-1:0]  deadline_new;
  logic [TIME_W-1:0]  since_dl;
  logic               ovf_eff;
  logic               blk_eff;
  logic [CNT_W-1:0]   cnt_eff;
  logic               load;
  logic               ld_last;
  status_t            st;

  assign out_free     = !out_valid_r || out_tready;
  assign in_tready    = (state_r == S_IDLE) && out_free;
  assign in_fire      = in_tvalid && in_tready;
  assign room         = bc_r < FB_CNT;
  assign src_ok       = (in_src != '0) && (in_src <= NODE_MAX);
  assign deadline_new = in_now + {16'd0, delay_r};
  assign since_dl     = in_now - dl_r;
  assign ovf_eff      = ovf_r || !room;
  assign blk_eff      = blk_r || (room && pend_r);
  assign cnt_eff      = room ? bc_r + CNT_W'(1) : bc_r;
  assign load         = (state_r == S_REPLAY) && rd_vld_r && out_free;
  assign ld_last      = (ld_cnt_r + CNT_W'(1)) == len_r;

  // next-state logic
  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    len_nxt       = len_r;
    hcmd_nxt      = hcmd_r;
    hsess_nxt     = hsess_r;
    dl_nxt        = dl_r;
    hmtype_nxt    = hmtype_r;
    hsrc_nxt      = hsrc_r;
    bc_nxt        = bc_r;
    ovf_nxt       = ovf_r;
    blk_nxt       = blk_r;
    rd_addr_nxt   = rd_addr_r;
    ld_cnt_nxt    = ld_cnt_r;
    rd_vld_nxt    = rd_vld_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    st            = ST_OK;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_kind)
            // frame byte; the last one commits the run
            KIND_STORE: begin
              ram_we  = room && !pend_r;
              bc_nxt  = cnt_eff;
              ovf_nxt = ovf_eff;
              blk_nxt = blk_eff;
              if (in_tlast) begin
                if (ovf_eff || (in_cmd == '0) || (in_sess == '0) || !src_ok) begin
                  st = ST_BAD;
                end else if (pend_r || blk_eff) begin
                  st = ST_FULL;
                end else begin
                  pend_nxt   = 1'b1;
                  len_nxt    = cnt_eff;
                  hcmd_nxt   = in_cmd;
                  hsess_nxt  = in_sess;
                  dl_nxt     = deadline_new;
                  hmtype_nxt = in_mtype;
                  hsrc_nxt   = in_src;
                end
                bc_nxt        = '0;
                ovf_nxt       = 1'b0;
                blk_nxt       = 1'b0;
                out_valid_nxt = 1'b1;
              end
            end
            // replay once the deadline has passed (signed wrap-safe test)
            KIND_PEEK: begin
              if (!pend_r) begin
                st            = ST_EMPTY;
                out_valid_nxt = 1'b1;
              end else if (!in_link || since_dl[TIME_W-1]) begin
                st            = ST_NOT_READY;
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt   = S_REPLAY;
                rd_addr_nxt = '0;
                ld_cnt_nxt  = '0;
                rd_vld_nxt  = 1'b0;
              end
            end
            // clear on success, re-arm otherwise
            KIND_FINISH: begin
              if (in_cmd == '0) begin
                st = ST_BAD;
              end else if (!pend_r) begin
                st = ST_EMPTY;
              end else if (hcmd_r != in_cmd) begin
                st = ST_CONFLICT;
              end else if (in_succ) begin
                pend_nxt   = 1'b0;
                len_nxt    = '0;
                hcmd_nxt   = '0;
                hsess_nxt  = '0;
                dl_nxt     = '0;
                hmtype_nxt = '0;
                hsrc_nxt   = '0;
              end else begin
                dl_nxt = deadline_new;
              end
              out_valid_nxt = 1'b1;
            end
            // drop a frame left by an older session of the same source
            KIND_DISCARD: begin
              if (!src_ok || (in_sess == '0) || !pend_r || (hsrc_r != in_src) ||
                  (hsess_r >= in_sess)) begin
                st = ST_NOT_DISCARDED;
              end else begin
                pend_nxt   = 1'b0;
                len_nxt    = '0;
                hcmd_nxt   = '0;
                hsess_nxt  = '0;
                dl_nxt     = '0;
                hmtype_nxt = '0;
                hsrc_nxt   = '0;
              end
              out_valid_nxt = 1'b1;
            end
            default: begin
            end
          endcase
          // status-only beat
          if (out_valid_nxt) begin
            out_nxt         = '0;
            out_nxt.status  = st;
            out_nxt.pending = pend_nxt;
            out_nxt.last    = 1'b1;
          end
        end
      end

      // stream stored bytes out of the RAM, one read kept ahead
      S_REPLAY: begin
        ram_re = (rd_addr_r < len_r) && (!rd_vld_r || load);
        if (ram_re) begin
          rd_addr_nxt = rd_addr_r + CNT_W'(1);
        end
        rd_vld_nxt = ram_re || (rd_vld_r && !load);
        if (load) begin
          out_nxt.status   = ST_OK;
          out_nxt.pending  = 1'b1;
          out_nxt.data_b   = ram_rdata;
          out_nxt.last     = ld_last;
          out_nxt.length   = len_r;
          out_nxt.cmd_id   = hcmd_r;
          out_nxt.msg_type = hmtype_r;
          out_nxt.src_node = hsrc_r;
          out_valid_nxt    = 1'b1;
          ld_cnt_nxt       = ld_cnt_r + CNT_W'(1);
          if (ld_last) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control and slot registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      len_r       <= '0;
      hcmd_r      <= '0;
      hsess_r     <= '0;
      dl_r        <= '0;
      hmtype_r    <= '0;
      hsrc_r      <= '0;
      bc_r        <= '0;
      ovf_r       <= 1'b0;
      blk_r       <= 1'b0;
      rd_addr_r   <= '0;
      ld_cnt_r    <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      len_r       <= len_nxt;
      hcmd_r      <= hcmd_nxt;
      hsess_r     <= hsess_nxt;
      dl_r        <= dl_nxt;
      hmtype_r    <= hmtype_nxt;
      hsrc_r      <= hsrc_nxt;
      bc_r        <= bc_nxt;
      ovf_r       <= ovf_nxt;
      blk_r       <= blk_nxt;
      rd_addr_r   <= rd_addr_nxt;
      ld_cnt_r    <= ld_cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output beat register (payload, no reset)
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {out_r.src_node, out_r.msg_type, out_r.cmd_id, out_r.length,
                       out_r.data_b, out_r.pending};

  // checks
  a_ram_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_IDLE))
    else $error("frame RAM written during replay");

  a_replay_holds_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REPLAY) |-> (pend_r && (len_r != '0) && (ld_cnt_r < len_r)))
    else $error("replay without a held frame");

  a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REPLAY) |-> ((rd_addr_r <= len_r) && (ld_cnt_r <= rd_addr_r)))
    else $error("replay read pointer out of range");

  a_read_data_owner: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == S_REPLAY))
    else $error("RAM data marked valid outside replay");

  a_pending_len: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> ((len_r != '0) && (len_r <= FB_CNT)))
    else $error("held frame length out of range");

endmodule

// ===== rtl/core/scr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module scr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the single-slot command retry buffer. A scored
// table of directed beats is followed by randomised store runs, peeks,
// finishes and discards under several retry delays. An in-bench model of the
// slot predicts every result beat, which is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import scr_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int FRAME_BYTES = 64;
  localparam int NODE_LIMIT  = 8;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int PHASE_BEATS = 48;
  localparam bit PINNED      = 1'b1;
  localparam bit PREDICTED   = 1'b0;

  // One input beat, unpacked
  typedef struct packed {
    kind_t       kind;
    logic [31:0] now;
    logic [31:0] cmd;
    logic [31:0] sess;
    logic [7:0]  mtype;
    logic [7:0]  src;
    logic [7:0]  dbyte;
    logic        last;
    logic        ready;
    logic        ok_fin;
  } cmd_item_t;

  // One result beat, unpacked
  typedef struct packed {
    status_t     status;
    logic        pending;
    logic [7:0]  dbyte;
    logic        last;
    logic [6:0]  length;
    logic [31:0] cmd;
    logic [7:0]  mtype;
    logic [7:0]  src;
  } reply_t;

  // Directed row: a beat plus an optional hand-written status
  typedef struct packed {
    cmd_item_t item;
    logic      pinned;
    status_t   pin_st;
    logic      pin_pend;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;   // now, cmd_id, sess_id, msg_type, src_node, byte, rdy, ok
  logic [1:0]   in_tuser;   // kind
  logic         in_tlast;   // data_last
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;  // pending, byte, length, cmd_id, msg_type, src_node
  logic [2:0]   out_tuser;  // status
  logic         out_tlast;  // out_last
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [2:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  single_slot_command_retry #(
    .FRAME_BYTES(FRAME_BYTES),
    .NODE_LIMIT (NODE_LIMIT)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  int          errors    = 0;
  int          items_sent = 0;
  int          gap_pct   = 0;
  int          stall_pct = 0;
  int          rx_hold   = 0;
  int unsigned cycles    = 0;
  logic [31:0] clock_ms  = '0;
  reply_t      replies_due[$];

  // Slot model
  logic        slot_held   = 1'b0;
  logic [7:0]  frame_mem [FRAME_BYTES];
  logic [6:0]  frame_len   = '0;
  logic [31:0] hold_cmd    = '0;
  logic [31:0] hold_sess   = '0;
  logic [31:0] retry_at    = '0;
  logic [7:0]  hold_mtype  = '0;
  logic [7:0]  hold_src    = '0;
  logic [6:0]  run_count   = '0;
  logic        run_over    = 1'b0;
  logic        run_blocked = 1'b0;
  logic [15:0] delay_ms    = 16'd100;

  function automatic bit node_ok(input logic [7:0] src);
    return src >= 1 && src <= NODE_LIMIT;
  endfunction

  function automatic void free_slot();
    slot_held  = 1'b0;
    frame_len  = '0;
    hold_cmd   = '0;
    hold_sess  = '0;
    retry_at   = '0;
    hold_mtype = '0;
    hold_src   = '0;
  endfunction

  // Advance the slot model by one accepted beat and queue its result beats
  function automatic void predict_replies(input cmd_item_t it);
    reply_t      r;
    status_t     st;
    logic [31:0] lag;
    r  = '0;
    st = ST_OK;
    case (it.kind)
      KIND_STORE: begin
        if (run_count >= FRAME_BYTES) begin
          run_over = 1'b1;
        end else begin
          if (slot_held) run_blocked = 1'b1;
          else frame_mem[run_count[5:0]] = it.dbyte;
          run_count++;
        end
        if (!it.last) return;
        if (run_over || it.cmd == 0 || it.sess == 0 || !node_ok(it.src)) begin
          st = ST_BAD;
        end else if (slot_held || run_blocked) begin
          st = ST_FULL;
        end else begin
          slot_held  = 1'b1;
          frame_len  = run_count;
          hold_cmd   = it.cmd;
          hold_sess  = it.sess;
          retry_at   = it.now + {16'd0, delay_ms};
          hold_mtype = it.mtype;
          hold_src   = it.src;
        end
        run_count   = '0;
        run_over    = 1'b0;
        run_blocked = 1'b0;
      end
      KIND_PEEK: begin
        lag = it.now - retry_at;
        if (!slot_held) begin
          st = ST_EMPTY;
        end else if (!it.ready || lag[31]) begin
          st = ST_NOT_READY;
        end else begin
          // replay the held frame, one beat per byte
          for (int k = 0; k < frame_len; k++) begin
            r         = '0;
            r.status  = ST_OK;
            r.pending = 1'b1;
            r.dbyte   = frame_mem[k];
            r.last    = (k + 1 == frame_len);
            r.length  = frame_len;
            r.cmd     = hold_cmd;
            r.mtype   = hold_mtype;
            r.src     = hold_src;
            replies_due.push_back(r);
          end
          return;
        end
      end
      KIND_FINISH: begin
        if (it.cmd == 0) st = ST_BAD;
        else if (!slot_held) st = ST_EMPTY;
        else if (hold_cmd != it.cmd) st = ST_CONFLICT;
        else if (it.ok_fin) free_slot();
        else retry_at = it.now + {16'd0, delay_ms};
      end
      default: begin
        if (!node_ok(it.src) || it.sess == 0 || !slot_held ||
            hold_src != it.src || hold_sess >= it.sess) begin
          st = ST_NOT_DISCARDED;
        end else begin
          free_slot();
        end
      end
    endcase
    r.status  = st;
    r.pending = slot_held;
    r.last    = 1'b1;
    replies_due.push_back(r);
  endfunction

  function automatic cmd_item_t rand_item();
    cmd_item_t it;
    it.kind   = kind_t'(2'($urandom_range(0, 3)));
    it.now    = $urandom;
    it.cmd    = $urandom;
    it.sess   = $urandom;
    it.mtype  = 8'($urandom_range(0, 255));
    it.src    = 8'($urandom_range(0, 255));
    it.dbyte  = 8'($urandom_range(0, 255));
    it.last   = 1'($urandom_range(0, 1));
    it.ready  = 1'($urandom_range(0, 1));
    it.ok_fin = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic dir_row_t step_row(
    input kind_t kind, input logic [31:0] now, input logic [31:0] cmd,
    input logic [31:0] sess, input logic [7:0] mtype, input logic [7:0] src,
    input logic [7:0] dbyte, input logic last, input logic ready,
    input logic ok_fin, input logic pinned, input status_t pin_st,
    input logic pin_pend);
    dir_row_t row;
    row.item     = '{kind, now, cmd, sess, mtype, src, dbyte, last, ready, ok_fin};
    row.pinned   = pinned;
    row.pin_st   = pin_st;
    row.pin_pend = pin_pend;
    return row;
  endfunction

  // Present one beat, hold it until taken, then queue its predicted results
  task automatic send_item(input cmd_item_t it, input bit pinned = 1'b0,
                           input status_t pin_st = ST_OK, input bit pin_pend = 1'b0);
    int     gap;
    int     depth;
    reply_t r;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 17);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.kind;
    in_tlast  <= it.last;
    in_tdata  <= {6'd0, it.ok_fin, it.ready, it.dbyte, it.src, it.mtype,
                  it.sess, it.cmd, it.now};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    depth = replies_due.size();
    predict_replies(it);
    if (pinned) begin
      // hand-written status stands in for the model's single beat
      while (replies_due.size() > depth) void'(replies_due.pop_back());
      r         = '0;
      r.status  = pin_st;
      r.pending = pin_pend;
      r.last    = 1'b1;
      replies_due.push_back(r);
    end
  endtask

  // Stop sending and wait for every outstanding result
  task automatic settle_replies(input int tail);
    in_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // Register write followed by a read-back, back to back on the bus
  task automatic program_delay(input logic [15:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_RETRY_DELAY, 2'b00};
    cfg_pwdata  <= {16'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    delay_ms    = value;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[15:0] !== value) begin
      errors++;
      $display("%0t: retry_delay_ms read-back expected %0h, got %0h",
               $time, value, cfg_prdata[15:0]);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // A store run of len beats; spoil breaks one header field of the commit
  task automatic store_run(input int len, input bit spoil, input bit noisy);
    cmd_item_t it;
    for (int i = 0; i < len; i++) begin
      it      = rand_item();
      it.kind = KIND_STORE;
      it.last = (i == len - 1);
      if (it.last) begin
        it.now = clock_ms;
        it.src = 8'($urandom_range(1, NODE_LIMIT));
        if (spoil) begin
          case ($urandom_range(0, 3))
            0:       it.cmd  = '0;
            1:       it.sess = '0;
            2:       it.src  = '0;
            default: it.src  = 8'($urandom_range(NODE_LIMIT + 1, 255));
          endcase
        end
      end
      send_item(it);
      if (noisy && !it.last && $urandom_range(0, 49) == 0) send_item(rand_item());
    end
  endtask

  // Peek, aimed around the deadline or at a random time
  task automatic do_peek(input int jitter, input bit aim);
    cmd_item_t it;
    it      = rand_item();
    it.kind = KIND_PEEK;
    if (aim) begin
      it.now   = retry_at + 32'($urandom_range(0, 2 * jitter)) - 32'(jitter);
      it.ready = (jitter == 0) ? 1'b1 : ($urandom_range(0, 6) != 0);
    end
    send_item(it);
  endtask

  task automatic do_finish(input bit aim, input bit force_ok);
    cmd_item_t it;
    it      = rand_item();
    it.kind = KIND_FINISH;
    it.now  = clock_ms;
    if (aim) it.cmd = hold_cmd;
    else if ($urandom_range(0, 9) == 0) it.cmd = '0;
    if (force_ok) it.ok_fin = 1'b1;
    send_item(it);
  endtask

  // Mostly well-formed traffic with some noise; squeeze drains once midway
  task automatic random_phase(input int quota, input bit squeeze);
    int        start;
    int        pick;
    int        len;
    cmd_item_t it;
    start = items_sent;
    while (items_sent - start < quota) begin
      if (squeeze && items_sent - start >= quota / 2) begin
        settle_replies(0);
        squeeze = 1'b0;
      end
      clock_ms += 32'($urandom_range(0, 60));
      if ($urandom_range(0, 49) == 0)
        clock_ms = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FF00 + 32'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        len = $urandom_range(0, 99);
        if (len < 75) len = $urandom_range(1, 6);
        else if (len < 90) len = $urandom_range(7, 20);
        else if (len < 96) len = $urandom_range(FRAME_BYTES - 4, FRAME_BYTES);
        else len = $urandom_range(FRAME_BYTES + 1, FRAME_BYTES + 4);
        store_run(len, $urandom_range(0, 9) == 0, 1'b1);
      end else if (pick < 65) begin
        do_peek(3, $urandom_range(0, 4) != 0);
      end else if (pick < 82) begin
        do_finish($urandom_range(0, 3) != 0, 1'b0);
      end else if (pick < 95) begin
        it      = rand_item();
        it.kind = KIND_DISCARD;
        if ($urandom_range(0, 9) < 7) begin
          it.src  = hold_src;
          it.sess = hold_sess + 32'($urandom_range(0, 2)) - 32'd1;
        end else if ($urandom_range(0, 3) == 0) begin
          it.sess = '0;
        end
        send_item(it);
      end else begin
        send_item(rand_item());
      end
    end
  endtask

  // Result side back-pressure in bursts
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold    <= rx_hold - 1;
      out_tready <= (rx_hold == 1);
    end else if ($urandom_range(0, 99) < stall_pct) begin
      rx_hold    <= $urandom_range(1, 17);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Score each result beat against the oldest expectation
  always @(posedge clk) begin : result_check
    reply_t got;
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status  = status_t'(out_tuser);
      got.pending = out_tdata[0];
      got.dbyte   = out_tdata[8:1];
      got.length  = out_tdata[15:9];
      got.cmd     = out_tdata[47:16];
      got.mtype   = out_tdata[55:48];
      got.src     = out_tdata[63:56];
      got.last    = out_tlast;
      if (replies_due.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, expected none, got %h/%h/%b",
                 $time, out_tuser, out_tdata, out_tlast);
      end else begin
        want = replies_due.pop_front();
        check_field("status",       32'(want.status),  32'(got.status));
        check_field("slot_pending", 32'(want.pending), 32'(got.pending));
        check_field("out_byte",     32'(want.dbyte),   32'(got.dbyte));
        check_field("out_last",     32'(want.last),    32'(got.last));
        check_field("out_length",   32'(want.length),  32'(got.length));
        check_field("out_cmd_id",   want.cmd,          got.cmd);
        check_field("out_msg_type", 32'(want.mtype),   32'(got.mtype));
        check_field("out_src_node", 32'(want.src),     32'(got.src));
      end
    end
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin : watchdog
    wait (cycles >= CYCLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : main
    dir_row_t    plan[$];
    logic [15:0] dly;
    foreach (frame_mem[i]) frame_mem[i] = '0;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= KIND_STORE;
    in_tlast    <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, reset delay of 100 ms
    gap_pct   = 15;
    stall_pct = 10;
    plan.push_back(step_row(KIND_PEEK,    0, 0, 0, 0, 0, 0, 0, 1, 0,
                            PINNED, ST_EMPTY, 0));
    plan.push_back(step_row(KIND_FINISH,  0, 0, 0, 0, 0, 0, 0, 0, 1,
                            PINNED, ST_BAD, 0));
    plan.push_back(step_row(KIND_FINISH,  0, 5, 0, 0, 0, 0, 0, 0, 1,
                            PINNED, ST_EMPTY, 0));
    plan.push_back(step_row(KIND_DISCARD, 0, 0, 1, 0, 1, 0, 0, 0, 0,
                            PINNED, ST_NOT_DISCARDED, 0));
    // single zero byte frame, deadline 100
    plan.push_back(step_row(KIND_STORE,   0, 1, 1, 8'h00, 1, 8'h00, 1, 0, 0,
                            PINNED, ST_OK, 1));
    plan.push_back(step_row(KIND_PEEK,   99, 0, 0, 0, 0, 0, 0, 1, 0,
                            PINNED, ST_NOT_READY, 1));
    plan.push_back(step_row(KIND_PEEK,  100, 0, 0, 0, 0, 0, 0, 0, 0,
                            PINNED, ST_NOT_READY, 1));
    plan.push_back(step_row(KIND_PEEK,  100, 0, 0, 0, 0, 0, 0, 1, 0,
                            PREDICTED, ST_OK, 0));
    // bad argument wins over full
    plan.push_back(step_row(KIND_STORE,   0, 0, 1, 0, 1, 0, 1, 0, 0,
                            PINNED, ST_BAD, 1));
    plan.push_back(step_row(KIND_STORE,   0, 7, 7, 0, 3, 0, 1, 0, 0,
                            PINNED, ST_FULL, 1));
    plan.push_back(step_row(KIND_FINISH,  0, 2, 0, 0, 0, 0, 0, 0, 1,
                            PINNED, ST_CONFLICT, 1));
    // re-arm close to the wrap point, deadline lands past zero
    plan.push_back(step_row(KIND_FINISH, 32'hFFFF_FFF0, 1, 0, 0, 0, 0, 0, 0, 0,
                            PINNED, ST_OK, 1));
    plan.push_back(step_row(KIND_PEEK, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 1, 0,
                            PINNED, ST_NOT_READY, 1));
    plan.push_back(step_row(KIND_PEEK, 32'h54, 0, 0, 0, 0, 0, 0, 1, 0,
                            PREDICTED, ST_OK, 0));
    plan.push_back(step_row(KIND_DISCARD, 0, 0, 1, 0, 1, 0, 0, 0, 0,
                            PINNED, ST_NOT_DISCARDED, 1));
    plan.push_back(step_row(KIND_DISCARD, 0, 0, 9, 0, 2, 0, 0, 0, 0,
                            PINNED, ST_NOT_DISCARDED, 1));
    // run starts while the slot is held, slot then freed: still full
    plan.push_back(step_row(KIND_STORE,   0, 0, 0, 0, 0, 8'hAA, 0, 0, 0,
                            PREDICTED, ST_OK, 0));
    plan.push_back(step_row(KIND_DISCARD, 0, 0, 32'hFFFF_FFFF, 0, 1, 0, 0, 0, 0,
                            PINNED, ST_OK, 0));
    plan.push_back(step_row(KIND_STORE,   0, 3, 3, 0, 1, 8'h55, 1, 0, 0,
                            PINNED, ST_FULL, 0));
    // two-byte frame with every header field at its top value
    plan.push_back(step_row(KIND_STORE,   0, 0, 0, 0, 0, 8'hFF, 0, 0, 0,
                            PREDICTED, ST_OK, 0));
    plan.push_back(step_row(KIND_STORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            8'hFF, 8'(NODE_LIMIT), 8'h00, 1, 0, 0, PINNED, ST_OK, 1));
    plan.push_back(step_row(KIND_STORE,   0, 1, 1, 0, 8'(NODE_LIMIT + 1), 8'h01, 1, 0, 0,
                            PINNED, ST_BAD, 1));
    plan.push_back(step_row(KIND_PEEK, 32'h63, 0, 0, 0, 0, 0, 0, 1, 0,
                            PREDICTED, ST_OK, 0));
    plan.push_back(step_row(KIND_FINISH,  0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 1,
                            PINNED, ST_OK, 0));
    plan.push_back(step_row(KIND_STORE,   0, 1, 1, 0, 0, 0, 1, 0, 0,
                            PINNED, ST_BAD, 0));
    foreach (plan[i])
      send_item(plan[i].item, plan[i].pinned, plan[i].pin_st, plan[i].pin_pend);

    // Full-size frame, its replay, then an over-long run
    store_run(FRAME_BYTES, 1'b0, 1'b0);
    do_peek(0, 1'b1);
    do_finish(1'b1, 1'b1);
    store_run(FRAME_BYTES + 2, 1'b0, 1'b0);

    // Random phases, each under its own retry delay
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin dly = 16'd0;          gap_pct = 15; stall_pct = 10; end
        1: begin dly = 16'hFFFF;       gap_pct = 25; stall_pct = 25; end
        2: begin dly = 16'($urandom);  gap_pct = 0;  stall_pct = 0;  end
        3: begin dly = 16'd1;          gap_pct = 10; stall_pct = 10; end
        default: begin dly = 16'($urandom); gap_pct = 0; stall_pct = 0; end
      endcase
      settle_replies(4);
      program_delay(dly);
      random_phase(PHASE_BEATS, p == 1);
    end

    settle_replies(20);
    if (errors == 0 && replies_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
